FILE: rtl/twb_pkg.sv
// Shared types, widths and codes of the threshold window blur.
package twb_pkg;

    localparam int CHANNEL_BITS   = 16;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int RAD_W   = 4;
    localparam int STEP_W  = 3;
    localparam int THR_W   = 18;
    localparam int RING_W  = 5;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 14;
    localparam int LIN_W   = 27;
    localparam int POS_W   = 16;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = CHANNEL_BITS + CNT_W;
    localparam int DIST_W  = 18;
    localparam int MAX_SAMPLES = 900;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHANNEL_BITS-1:0] ONE_FIX = CHANNEL_BITS'(4096);
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_RADIUS = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_THRESH = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                    req_type;
        logic [CHANNEL_BITS-1:0] color_red;
        logic [CHANNEL_BITS-1:0] color_green;
        logic [CHANNEL_BITS-1:0] color_blue;
        logic [CHANNEL_BITS-1:0] color_alpha;
        logic [CHANNEL_BITS-1:0] guide_red;
        logic [CHANNEL_BITS-1:0] guide_green;
        logic [CHANNEL_BITS-1:0] guide_blue;
    } t_twb_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_red;
        logic [CHANNEL_BITS-1:0] out_green;
        logic [CHANNEL_BITS-1:0] out_blue;
        logic [CHANNEL_BITS-1:0] out_alpha;
        logic                    frame_end;
    } t_twb_out;

    // effective (clamped) configuration
    typedef struct packed {
        logic [WID_W-1:0]  width;
        logic [HGT_W-1:0]  height;
        logic [RAD_W-1:0]  radius;
        logic [STEP_W-1:0] step;
        logic [RING_W-1:0] ring_rows;
        logic [THR_W-1:0]  threshold;
    } t_twb_cfg;

    typedef struct packed {
        logic                      do_write;
        logic                      do_filter;
        logic                      frame_end;
        logic [RING_W-1:0]         wr_ring;
        logic [COL_W-1:0]          wr_col;
        logic [4*CHANNEL_BITS-1:0] color;
        logic [3*CHANNEL_BITS-1:0] guide;
        logic [COL_W-1:0]          out_col;
        logic [ROW_W-1:0]          out_row;
        logic [RING_W-1:0]         out_ring;
    } t_twb_job;

    typedef enum logic [3:0] {
        F_IDLE, F_MUL, F_CHK, F_MOD_IN, F_ADV, F_MUL2, F_DEC, F_MOD_OUT, F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE, B_WRITE, B_CENTER, B_CWAIT, B_SCAN, B_DRAIN, B_LOAD, B_DIV, B_OUT
    } t_back_state;

endpackage

FILE: rtl/twb_queue.sv
// Short job queue between the classifying front and the filtering back.
module twb_queue import twb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_twb_job i_job,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_twb_job o_job
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_twb_job            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [CNT_QW-1:0]   r_count;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("job queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QUEUE_DEPTH)) else $error("job queue count out of range");

endmodule

FILE: rtl/twb_front.sv
// Front: accepts items, tracks raster positions and queues store and filter jobs.
module twb_front import twb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_twb_cfg i_cfg,
    input  logic     i_in_valid,
    input  t_twb_in  i_in_data,
    output logic     o_in_stall,
    output logic     o_push,
    output t_twb_job o_job,
    input  logic     i_full
);
    t_front_state r_state, n_state;
    t_twb_in      r_item;
    logic [COL_W-1:0]  r_icol, r_ocol, r_job_ocol;
    logic [ROW_W-1:0]  r_irow, r_orow, r_job_orow;
    logic [LIN_W-1:0]  r_in_lin, r_out_lin, r_total, r_lag;
    logic              r_wr, r_emit, r_fend;
    logic [RING_W-1:0] r_wr_ring, r_out_ring;
    logic [COL_W-1:0]  r_wr_col;
    logic [ROW_W-1:0]  r_mod_val;
    logic [RING_W-1:0] r_mod_rem;
    logic [3:0]        r_mod_cnt;

    logic [COL_W-1:0]  w_col;
    logic [LIN_W-1:0]  w_lin;
    logic [RAD_W-1:0]  rm1;
    logic [RING_W:0]   mod_t;
    logic [RING_W-1:0] mod_next;
    logic              take;

    assign w_col = COL_W'(i_cfg.width);
    assign w_lin = LIN_W'(i_cfg.width);
    assign rm1   = i_cfg.radius - 1'b1;
    assign take  = (r_state == F_IDLE) && i_in_valid;

    // one remainder bit per cycle
    assign mod_t    = {r_mod_rem, r_mod_val[ROW_W-1]};
    assign mod_next = (mod_t >= {1'b0, i_cfg.ring_rows}) ?
                      RING_W'(mod_t - {1'b0, i_cfg.ring_rows}) : RING_W'(mod_t);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:    if (i_in_valid) n_state = F_MUL;
            F_MUL:     n_state = F_CHK;
            F_CHK: begin
                if (r_in_lin < r_total) begin
                    n_state = (r_item.req_type == REQ_DRAIN) ? F_IDLE : F_MOD_IN;
                end else begin
                    n_state = F_ADV;
                end
            end
            F_MOD_IN:  if (r_mod_cnt == '0) n_state = F_ADV;
            F_ADV:     n_state = F_MUL2;
            F_MUL2:    n_state = F_DEC;
            F_DEC: begin
                if ((r_ocol >= w_col) || (r_out_lin >= r_total)
                    || (r_in_lin <= r_out_lin + r_lag)) begin
                    n_state = r_wr ? F_PUSH : F_IDLE;
                end else begin
                    n_state = F_MOD_OUT;
                end
            end
            F_MOD_OUT: if (r_mod_cnt == '0) n_state = F_PUSH;
            F_PUSH:    if (!i_full) n_state = F_IDLE;
            default:   n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        o_push     = (r_state == F_PUSH) && !i_full;
        o_job.do_write  = r_wr;
        o_job.do_filter = r_emit;
        o_job.frame_end = r_fend;
        o_job.wr_ring   = r_wr_ring;
        o_job.wr_col    = r_wr_col;
        o_job.color     = {r_item.color_red, r_item.color_green,
                           r_item.color_blue, r_item.color_alpha};
        o_job.guide     = {r_item.guide_red, r_item.guide_green, r_item.guide_blue};
        o_job.out_col   = r_job_ocol;
        o_job.out_row   = r_job_orow;
        o_job.out_ring  = r_out_ring;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_icol  <= '0;
            r_irow  <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_wr    <= 1'b0;
            r_emit  <= 1'b0;
            r_fend  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_CHK: begin
                    r_wr <= (r_in_lin < r_total);
                    r_wr_col  <= (r_icol < w_col) ? r_icol : '0;
                end
                F_ADV: begin
                    if (r_icol + 1'b1 >= w_col) begin
                        r_icol <= '0;
                        r_irow <= r_irow + 1'b1;
                    end else begin
                        r_icol <= r_icol + 1'b1;
                    end
                end
                F_DEC: begin
                    r_emit <= 1'b0;
                    r_fend <= 1'b0;
                    r_job_ocol <= r_ocol;
                    r_job_orow <= r_orow;
                    if ((r_ocol >= w_col) || (r_out_lin >= r_total)) begin
                        r_icol <= '0;
                        r_irow <= '0;
                        r_ocol <= '0;
                        r_orow <= '0;
                    end else if (r_in_lin > r_out_lin + r_lag) begin
                        r_emit <= 1'b1;
                        r_fend <= (r_out_lin + 1'b1 >= r_total);
                    end
                end
                F_MOD_OUT: begin
                    if (r_mod_cnt == '0) begin
                        if (r_fend) begin
                            r_icol <= '0;
                            r_irow <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                        end else if (r_ocol + 1'b1 >= w_col) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + 1'b1;
                        end else begin
                            r_ocol <= r_ocol + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_in_data;
        end
        case (r_state)
            F_MUL: begin
                r_in_lin <= LIN_W'(LIN_W'(r_irow) * w_lin) + LIN_W'(r_icol);
                r_total  <= LIN_W'(LIN_W'(i_cfg.height) * w_lin);
                r_lag    <= LIN_W'(LIN_W'(rm1) * w_lin)
                            + ((LIN_W'(rm1) < w_lin - 1'b1) ? LIN_W'(rm1) : w_lin - 1'b1);
            end
            F_CHK: begin
                r_mod_val <= r_irow;
                r_mod_rem <= '0;
                r_mod_cnt <= 4'(ROW_W - 1);
            end
            F_MUL2: begin
                r_in_lin  <= LIN_W'(LIN_W'(r_irow) * w_lin) + LIN_W'(r_icol);
                r_out_lin <= LIN_W'(LIN_W'(r_orow) * w_lin) + LIN_W'(r_ocol);
            end
            F_DEC: begin
                r_mod_val <= r_orow;
                r_mod_rem <= '0;
                r_mod_cnt <= 4'(ROW_W - 1);
            end
            F_MOD_IN, F_MOD_OUT: begin
                r_mod_rem <= mod_next;
                r_mod_val <= {r_mod_val[ROW_W-2:0], 1'b0};
                r_mod_cnt <= r_mod_cnt - 1'b1;
                if (r_mod_cnt == '0) begin
                    if (r_state == F_MOD_IN) begin
                        r_wr_ring <= mod_next;
                    end else begin
                        r_out_ring <= mod_next;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/twb_back.sv
// Back: line store, window scan, thresholded accumulation, division and result register.
module twb_back import twb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_twb_cfg i_cfg,
    input  logic     i_job_valid,
    input  t_twb_job i_job,
    output logic     o_pop,
    output logic     o_out_valid,
    output t_twb_out o_out_data,
    input  logic     i_out_stall
);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
    localparam int DEPTH     = RING_ROWS * (2 ** CW);
    localparam int AW        = $clog2(DEPTH);
    localparam int WORD_W    = 7 * CHANNEL_BITS;
    localparam int CB        = CHANNEL_BITS;

    t_back_state r_state, n_state;
    t_twb_job    r_job;
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic [AW-1:0]     rd_addr, wr_addr;

    logic signed [POS_W-1:0] r_xi, r_yi, cx, cy, rad_s, step_s, nx, ny;
    logic [RING_W-1:0] r_ring, start_ring, next_ring;
    logic [RING_W:0]   ring_t, start_t;
    logic [3*CB-1:0]   r_ref;
    logic              r_p_valid, r_p_in, inframe, last;

    logic [SUM_W-1:0]  r_sum [4];
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_q [4];
    logic [CNT_W-1:0]  r_rem [4];
    logic [4:0]        r_div_cnt;
    logic [CNT_W:0]    div_t [4];

    logic [WORD_W-1:0] sample;
    logic [DIST_W-1:0] gdist;
    logic              hit, load_out, out_take;
    t_twb_out          r_out, res;
    logic              r_out_valid;

    function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    assign cx     = POS_W'(r_job.out_col);
    assign cy     = POS_W'(r_job.out_row);
    assign rad_s  = POS_W'(i_cfg.radius);
    assign step_s = POS_W'(i_cfg.step);
    assign nx     = r_xi + step_s;
    assign ny     = r_yi + step_s;
    assign last   = (nx >= cx + rad_s) && (ny >= cy + rad_s);

    assign start_t    = {1'b0, r_job.out_ring} + {1'b0, i_cfg.ring_rows}
                        - (RING_W + 1)'(i_cfg.radius);
    assign start_ring = (start_t >= {1'b0, i_cfg.ring_rows}) ?
                        RING_W'(start_t - {1'b0, i_cfg.ring_rows}) : RING_W'(start_t);
    assign ring_t     = {1'b0, r_ring} + (RING_W + 1)'(i_cfg.step);
    assign next_ring  = (ring_t >= {1'b0, i_cfg.ring_rows}) ?
                        RING_W'(ring_t - {1'b0, i_cfg.ring_rows}) : RING_W'(ring_t);

    assign inframe = (r_xi >= 0) && (r_yi >= 0) && (r_xi < POS_W'(i_cfg.width))
                     && (r_yi < POS_W'(i_cfg.height));

    assign wr_addr = AW'({r_job.wr_ring, r_job.wr_col[CW-1:0]});
    assign rd_addr = (r_state == B_CENTER) ? AW'({r_job.out_ring, r_job.out_col[CW-1:0]})
                                           : AW'({r_ring, r_xi[CW-1:0]});

    always_ff @(posedge i_clk) begin
        if (r_state == B_WRITE) begin
            r_mem[wr_addr] <= {r_job.color, r_job.guide};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign sample = r_p_in ? r_rd : '0;
    assign gdist  = DIST_W'(absdiff(r_ref[3*CB-1:2*CB], sample[3*CB-1:2*CB]))
                  + DIST_W'(absdiff(r_ref[2*CB-1:CB], sample[2*CB-1:CB]))
                  + DIST_W'(absdiff(r_ref[CB-1:0], sample[CB-1:0]));
    assign hit    = r_p_valid && (gdist < i_cfg.threshold);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            div_t[k] = {r_rem[k], r_q[k][SUM_W-1]};
        end
    end

    always_comb begin
        res.frame_end = r_job.frame_end;
        if (r_cnt == '0) begin
            res.out_red   = '0;
            res.out_green = '0;
            res.out_blue  = '0;
            res.out_alpha = ONE_FIX;
        end else begin
            res.out_red   = r_q[0][CB-1:0];
            res.out_green = r_q[1][CB-1:0];
            res.out_blue  = r_q[2][CB-1:0];
            res.out_alpha = r_q[3][CB-1:0];
        end
    end

    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:   if (i_job_valid) n_state = i_job.do_write ? B_WRITE : B_CENTER;
            B_WRITE:  n_state = r_job.do_filter ? B_CENTER : B_IDLE;
            B_CENTER: n_state = B_CWAIT;
            B_CWAIT:  n_state = B_SCAN;
            B_SCAN:   if (last) n_state = B_DRAIN;
            B_DRAIN:  n_state = B_LOAD;
            B_LOAD:   n_state = B_DIV;
            B_DIV:    if (r_div_cnt == 5'd1) n_state = B_OUT;
            B_OUT:    if (!r_out_valid || !i_out_stall) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && i_job_valid;
        load_out = (r_state == B_OUT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == B_SCAN);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_out <= res;
        end
        r_p_in <= inframe;
        case (r_state)
            B_CENTER: begin
                r_xi   <= cx - rad_s;
                r_yi   <= cy - rad_s;
                r_ring <= start_ring;
                r_cnt  <= '0;
                for (int k = 0; k < 4; k++) r_sum[k] <= '0;
            end
            B_CWAIT: r_ref <= r_rd[3*CB-1:0];
            B_SCAN: begin
                if (nx < cx + rad_s) begin
                    r_xi <= nx;
                end else begin
                    r_xi   <= cx - rad_s;
                    r_yi   <= ny;
                    r_ring <= next_ring;
                end
            end
            B_LOAD: begin
                r_div_cnt <= 5'(SUM_W);
                for (int k = 0; k < 4; k++) begin
                    r_q[k]   <= r_sum[k];
                    r_rem[k] <= '0;
                end
            end
            B_DIV: begin
                r_div_cnt <= r_div_cnt - 1'b1;
                for (int k = 0; k < 4; k++) begin
                    if (div_t[k] >= {1'b0, r_cnt}) begin
                        r_rem[k] <= CNT_W'(div_t[k] - {1'b0, r_cnt});
                        r_q[k]   <= {r_q[k][SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= CNT_W'(div_t[k]);
                        r_q[k]   <= {r_q[k][SUM_W-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
        // accumulate the sample addressed in the previous cycle
        if (hit) begin
            r_cnt <= r_cnt + 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= r_sum[k] + SUM_W'(sample[WORD_W-1-k*CB -: CB]);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_cnt <= CNT_W'(MAX_SAMPLES)))
        else $error("sample count beyond window size");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction changed while stalled");
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_div_cnt != '0))
        else $error("divider step count ran out");

endmodule

FILE: rtl/threshold_window_blur_top.sv
// Top level of the threshold window blur: registers, front, job queue and back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_twb_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_twb_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The front handles a drain before the frame is full, and a tick that neither stores
// nor emits, without a row-modulo pass; a stored pixel needs one 14-step pass, and
// scheduling a result adds a second, plus any wait on a full queue. For each result
// the back does one line store read per window sample plus a 26-step divider, after
// a line store write when the job also stores a pixel.
// Reset is synchronous; the line store is not cleared.
// A stalled output holds the back; the two-entry job queue then fills and
// stalls the input.
module threshold_window_blur_top import twb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_twb_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_twb_out              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [RAD_W-1:0]  r_radius;
    logic [STEP_W-1:0] r_step;
    logic [THR_W-1:0]  r_thresh;
    t_twb_cfg          cfg;
    logic              push, full, pop, job_valid;
    t_twb_job          push_job, pop_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(1024);
            r_height <= HGT_W'(1024);
            r_radius <= RAD_W'(1);
            r_step   <= STEP_W'(1);
            r_thresh <= THR_W'(4096);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the registers into their working ranges
    always_comb begin
        if (r_width == '0) begin
            cfg.width = WID_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            cfg.width = WID_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        cfg.height = (r_height == '0) ? HGT_W'(1) : r_height;
        if (r_radius == '0) begin
            cfg.radius = RAD_W'(1);
        end else if (32'(r_radius) > MAX_RADIUS) begin
            cfg.radius = RAD_W'(MAX_RADIUS);
        end else begin
            cfg.radius = r_radius;
        end
        cfg.step      = (r_step == '0) ? STEP_W'(1) : r_step;
        cfg.ring_rows = {cfg.radius, 1'b1};
        cfg.threshold = r_thresh;
    end

    twb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    twb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (pop_job)
    );

    twb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: tb/twb_checker.sv
// Checker for the threshold window blur: watches the channels, predicts results and compares.
module twb_checker import twb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_twb_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_twb_out              i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_pending
);

    localparam int STORE_ROWS  = 2 * DEF_MAX_RADIUS + 1;
    localparam int STORE_DEPTH = STORE_ROWS * DEF_MAX_WIDTH;

    bit [4*CHANNEL_BITS-1:0] color_mem [STORE_DEPTH];
    bit [3*CHANNEL_BITS-1:0] guide_mem [STORE_DEPTH];

    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [STEP_W-1:0] step_reg;
    logic [THR_W-1:0]  thresh_reg;

    int in_col, in_row, out_col, out_row;
    t_twb_out blurred_q[$];
    int failures;

    assign o_failures = failures;
    assign o_pending  = blurred_q.size();

    function automatic void read_px(int x, int y, int w, int h, int r,
                                    output bit [4*CHANNEL_BITS-1:0] c,
                                    output bit [3*CHANNEL_BITS-1:0] g);
        int slot;
        if (x < 0 || y < 0 || x >= w || y >= h) begin
            c = '0;
            g = '0;
        end else begin
            slot = (y % (2 * r + 1)) * DEF_MAX_WIDTH + x;
            c = color_mem[slot];
            g = guide_mem[slot];
        end
    endfunction

    function automatic int chan_dist(bit [3*CHANNEL_BITS-1:0] a, bit [3*CHANNEL_BITS-1:0] b);
        int d;
        int av, bv;
        d = 0;
        for (int k = 0; k < 3; k++) begin
            av = a[k*CHANNEL_BITS +: CHANNEL_BITS];
            bv = b[k*CHANNEL_BITS +: CHANNEL_BITS];
            d += (av > bv) ? av - bv : bv - av;
        end
        return d;
    endfunction

    function automatic t_twb_out blur_pixel(int x, int y, int w, int h, int r, int s);
        bit [4*CHANNEL_BITS-1:0] cc, c;
        bit [3*CHANNEL_BITS-1:0] cg, g;
        longint sum [4];
        longint cnt;
        t_twb_out res;
        logic [CHANNEL_BITS-1:0] mean [4];
        for (int k = 0; k < 4; k++) sum[k] = 0;
        cnt = 0;
        read_px(x, y, w, h, r, cc, cg);
        for (int yi = y - r; yi < y + r; yi += s) begin
            for (int xi = x - r; xi < x + r; xi += s) begin
                read_px(xi, yi, w, h, r, c, g);
                if (chan_dist(cg, g) < int'(thresh_reg)) begin
                    for (int k = 0; k < 4; k++) sum[k] += c[k*CHANNEL_BITS +: CHANNEL_BITS];
                    cnt++;
                end
            end
        end
        // channel 3 of the packed color is red, channel 0 is alpha
        if (cnt == 0) begin
            for (int k = 0; k < 4; k++) mean[k] = '0;
            mean[0] = ONE_FIX;
        end else begin
            for (int k = 0; k < 4; k++) mean[k] = CHANNEL_BITS'(sum[k] / cnt);
        end
        res.out_red   = mean[3];
        res.out_green = mean[2];
        res.out_blue  = mean[1];
        res.out_alpha = mean[0];
        res.frame_end = 1'b0;
        return res;
    endfunction

    task automatic predict_blur(t_twb_in px);
        int w, h, r, s, total, lag, in_lin, out_lin, slot;
        t_twb_out res;
        w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        r = (radius_reg == 0) ? 1 : (radius_reg > DEF_MAX_RADIUS ? DEF_MAX_RADIUS
                                                                  : int'(radius_reg));
        s = (step_reg == 0) ? 1 : int'(step_reg);
        total = w * h;
        lag = (r - 1) * w + ((r - 1) < (w - 1) ? r - 1 : w - 1);
        in_lin = in_row * w + in_col;
        if (in_lin < total) begin
            // drop a drain that arrives while the frame is still filling
            if (px.req_type == REQ_DRAIN) return;
            slot = (in_row % (2 * r + 1)) * DEF_MAX_WIDTH + (in_col < w ? in_col : 0);
            color_mem[slot] = {px.color_red, px.color_green, px.color_blue, px.color_alpha};
            guide_mem[slot] = {px.guide_red, px.guide_green, px.guide_blue};
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        in_lin = in_row * w + in_col;
        out_lin = out_row * w + out_col;
        if (out_col >= w || out_lin >= total) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            return;
        end
        if (in_lin <= out_lin + lag) return;
        res = blur_pixel(out_col, out_row, w, h, r, s);
        if (out_lin + 1 >= total) begin
            res.frame_end = 1'b1;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        blurred_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_twb_out want;
        if (!i_rst_n) begin
            width_reg  <= WID_W'(1024);
            height_reg <= HGT_W'(1024);
            radius_reg <= RAD_W'(1);
            step_reg   <= STEP_W'(1);
            thresh_reg <= THR_W'(4096);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            blurred_q.delete();
            failures = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:  width_reg  <= WID_W'(i_cfg_data);
                    CFG_HEIGHT: height_reg <= HGT_W'(i_cfg_data);
                    CFG_RADIUS: radius_reg <= RAD_W'(i_cfg_data);
                    CFG_STEP:   step_reg   <= STEP_W'(i_cfg_data);
                    CFG_THRESH: thresh_reg <= THR_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_blur(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (blurred_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected output transaction: %p", i_out_data);
                end else begin
                    want = blurred_q.pop_front();
                    if (want !== i_out_data) begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/threshold_window_blur_top_tb.sv
// Testbench top for the threshold window blur: stimulus, configuration and verdict.
module threshold_window_blur_top_tb;
    import twb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_twb_in               in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_twb_out              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    pending;
    bit                    calm;
    int                    items_sent;

    threshold_window_blur_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    twb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 4_000_000);
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
    end

    function automatic logic [CHANNEL_BITS-1:0] pick_chan(bit guide);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return CHANNEL_BITS'($urandom);
            default: return guide ? CHANNEL_BITS'($urandom_range(3000, 5000))
                                  : CHANNEL_BITS'($urandom_range(8191));
        endcase
    endfunction

    function automatic t_twb_in make_item(bit drain);
        t_twb_in it;
        it.req_type    = drain;
        it.color_red   = pick_chan(0);
        it.color_green = pick_chan(0);
        it.color_blue  = pick_chan(0);
        it.color_alpha = pick_chan(0);
        it.guide_red   = pick_chan(1);
        it.guide_green = pick_chan(1);
        it.guide_blue  = pick_chan(1);
        return it;
    endfunction

    task automatic push_item(t_twb_in it);
        while (!calm && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // the front may still be busy on an item that gave no result
        repeat (80) @(posedge i_clk);
    endtask

    // set registers, then stream one full frame and its flush ticks
    task automatic blur_frame(int w, int h, int r, int s, int thr);
        int ew, eh, er, lag;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_STEP, s);
        write_reg(CFG_THRESH, thr);
        ew = (w == 0) ? 1 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w);
        eh = (h == 0) ? 1 : h;
        er = (r == 0) ? 1 : (r > DEF_MAX_RADIUS ? DEF_MAX_RADIUS : r);
        lag = (er - 1) * ew + ((er - 1) < (ew - 1) ? er - 1 : ew - 1);
        for (int i = 0; i < ew * eh; i++) begin
            if ($urandom_range(99) < 5) push_item(make_item(1'b1));
            push_item(make_item(1'b0));
        end
        for (int i = 0; i < lag; i++) push_item(make_item($urandom_range(1)));
        wait_idle();
    endtask

    initial begin
        int w, h, r, s, thr, frame_no;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: nothing qualifies, everything qualifies, clamped registers
        blur_frame(4, 3, 1, 1, 0);
        blur_frame(1, 1, 1, 1, 262143);
        blur_frame(0, 0, 0, 0, 4096);
        blur_frame(3, 2, 15, 7, 262143);
        blur_frame(2, 2, 8, 4, 3000);

        frame_no = 0;
        while (items_sent < 650) begin
            calm = (frame_no == 4);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            r = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
            s = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
            case ($urandom_range(3))
                0: thr = 0;
                1: thr = 262143;
                2: thr = $urandom_range(262143);
                default: thr = $urandom_range(12000);
            endcase
            blur_frame(w, h, r, s, thr);
            frame_no++;
        end
        calm = 1'b0;

        wait_idle();
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/twb_pkg.sv
rtl/twb_queue.sv
rtl/twb_front.sv
rtl/twb_back.sv
rtl/threshold_window_blur_top.sv
tb/twb_checker.sv
tb/threshold_window_blur_top_tb.sv
